/* hdl/uenc_pkg.sv */
package uenc_pkg;

    localparam int unsigned LENGTH_BITS_DEFAULT = 16;
    localparam int unsigned CFG_DATA_BITS       = 16;
    localparam int unsigned CFG_INDEX_BITS      = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_CASE    = 1'd1;

    localparam logic [31:0] BUFFER_LENGTH_RESET = 32'd256;
    localparam logic        UPPER_CASE_RESET    = 1'b1;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [3:0] NIBBLE_TEN   = 4'hA;

    localparam logic [1:0] COUNT_ONE   = 2'd1;
    localparam logic [1:0] COUNT_THREE = 2'd3;

    // results of one item, first byte in the lowest bits
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  count;
        logic        dropped;
    } grp_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (nib >= NIBBLE_TEN)
            return base + {4'h0, nib - NIBBLE_TEN};
        return CHAR_ZERO + {4'h0, nib};
    endfunction

    function automatic logic is_plain(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            || (c >= CHAR_ZERO && c <= CHAR_NINE)
            || c == CHAR_MINUS || c == CHAR_DOT || c == CHAR_TILDE;
    endfunction

endpackage

/* hdl/uenc_step.sv */
module uenc_step
    import uenc_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_data,
    input  logic [LENGTH_BITS-1:0] buffer_length,
    input  logic                   upper_case,
    output logic                   grp_valid,
    input  logic                   grp_ready,
    output grp_t                   grp
);

    logic                   in_valid_reg, in_valid_next;
    logic [7:0]             in_data_reg, in_data_next;
    logic [LENGTH_BITS-1:0] written_reg, written_next;
    logic                   stopped_reg, stopped_next;

    logic [LENGTH_BITS-1:0] capacity;
    logic [LENGTH_BITS+1:0] escape_end;
    logic                   full;
    logic                   take;

    assign in_ready  = !in_valid_reg || grp_ready;
    assign grp_valid = in_valid_reg;
    assign take      = in_valid_reg && grp_ready;

    assign capacity   = (buffer_length != '0) ? buffer_length - 1'b1 : '0;
    assign escape_end = {2'b00, written_reg} + (LENGTH_BITS+2)'(3);
    assign full       = stopped_reg || (written_reg >= capacity);

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
            if (in_valid)
                in_data_next = in_data;
        end
    end

    always_comb
    begin
        grp.data     = {16'h0000, CHAR_NUL};
        grp.count    = COUNT_ONE;
        grp.dropped  = 1'b0;
        written_next = written_reg;
        stopped_next = stopped_reg;
        priority if (in_data_reg == CHAR_NUL)
        begin
            written_next = '0;
            stopped_next = 1'b0;
        end
        else if (full)
        begin
            grp.dropped  = 1'b1;
            stopped_next = 1'b1;
        end
        else if (is_plain(in_data_reg))
        begin
            grp.data[7:0] = in_data_reg;
            written_next  = written_reg + 1'b1;
        end
        else if (in_data_reg == CHAR_SPACE)
        begin
            grp.data[7:0] = CHAR_PLUS;
            written_next  = written_reg + 1'b1;
        end
        else if (escape_end > {2'b00, capacity})
        begin
            grp.dropped  = 1'b1;
            stopped_next = 1'b1;
        end
        else
        begin
            grp.data     = {hex_digit(in_data_reg[3:0], upper_case),
                            hex_digit(in_data_reg[7:4], upper_case), CHAR_PERCENT};
            grp.count    = COUNT_THREE;
            written_next = escape_end[LENGTH_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            written_reg  <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (take)
            begin
                written_reg <= written_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

endmodule

/* hdl/uenc_serial.sv */
module uenc_serial
    import uenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       grp_valid,
    output logic       grp_ready,
    input  grp_t       grp,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       out_dropped
);

    logic        buf_valid_reg, buf_valid_next;
    logic [23:0] buf_data_reg, buf_data_next;
    logic [1:0]  buf_left_reg, buf_left_next;
    logic        buf_drop_reg, buf_drop_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    logic        out_drop_reg, out_drop_next;

    logic        out_load;
    logic        buf_final;

    assign out_load  = buf_valid_reg && (!out_valid_reg || out_ready);
    assign buf_final = (buf_left_reg == COUNT_ONE);
    assign grp_ready = !buf_valid_reg || (out_load && buf_final);

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        buf_data_next  = buf_data_reg;
        buf_left_next  = buf_left_reg;
        buf_drop_next  = buf_drop_reg;
        if (out_load)
        begin
            buf_data_next  = {8'h00, buf_data_reg[23:8]};
            buf_left_next  = buf_left_reg - 1'b1;
            buf_valid_next = !buf_final;
        end
        if (grp_ready && grp_valid)
        begin
            buf_valid_next = 1'b1;
            buf_data_next  = grp.data;
            buf_left_next  = grp.count;
            buf_drop_next  = grp.dropped;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_drop_next  = out_drop_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = buf_data_reg[7:0];
            out_last_next  = buf_final;
            out_drop_next  = buf_drop_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_data_reg <= buf_data_next;
        buf_left_reg <= buf_left_next;
        buf_drop_reg <= buf_drop_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_drop_reg <= out_drop_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign out_last    = out_last_reg;
    assign out_dropped = out_drop_reg;

endmodule

/* hdl/url_percent_encoder.sv */
// channel   | direction | tdata           | tlast       | tuser
// s_axis    | in        | [7:0] data_byte | -           | -
// m_axis    | out       | [7:0] out_byte  | last_of_run | dropped
// cfg       | in        | cfg_data: index 0 buffer_length, index 1 upper_case
//
// one output byte per cycle while m_axis_tready is high: an escape gives three
// items, every other source byte (plain, space, NUL or dropped) gives one
// the output register sets the pace; input, result buffer and output register
// overlap so a new source byte is taken while the previous results drain
// an accepted byte passes input register, result buffer, then output register
// reset clears the string count, the stop flag and all valid flags
module url_percent_encoder
    import uenc_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [7:0] data_byte
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
    output logic                      m_axis_tlast,
    output logic                      m_axis_tuser,   // [0] dropped
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [LENGTH_BITS-1:0] buffer_length_reg, buffer_length_next;
    logic                   upper_case_reg, upper_case_next;
    logic [31:0]            cfg_data_wide;

    logic grp_valid;
    logic grp_ready;
    grp_t grp;

    assign cfg_data_wide = {{(32-CFG_DATA_BITS){1'b0}}, cfg_data};

    always_comb
    begin
        buffer_length_next = buffer_length_reg;
        upper_case_next    = upper_case_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUFFER_LENGTH: buffer_length_next = cfg_data_wide[LENGTH_BITS-1:0];
                REG_UPPER_CASE:    upper_case_next    = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= BUFFER_LENGTH_RESET[LENGTH_BITS-1:0];
            upper_case_reg    <= UPPER_CASE_RESET;
        end
        else
        begin
            buffer_length_reg <= buffer_length_next;
            upper_case_reg    <= upper_case_next;
        end
    end

    uenc_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .buffer_length (buffer_length_reg),
        .upper_case    (upper_case_reg),
        .grp_valid     (grp_valid),
        .grp_ready     (grp_ready),
        .grp           (grp)
    );

    uenc_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .grp_valid   (grp_valid),
        .grp_ready   (grp_ready),
        .grp         (grp),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_last    (m_axis_tlast),
        .out_dropped (m_axis_tuser)
    );

endmodule

/* tb/sv/tb_url_percent_encoder.sv */
`timescale 1ns / 1ps

module tb_url_percent_encoder;
    import uenc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       dropped;
    } enc_char_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;   // [7:0] data_byte
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [7:0]                m_axis_tdata;   // [7:0] out_byte
    logic                      m_axis_tlast;
    logic                      m_axis_tuser;   // [0] dropped
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    logic [7:0] source_bytes[$];
    enc_char_t  expected_chars[$];

    // mirror of the encoder state and registers
    logic [15:0] buf_len_reg;
    logic        upper_reg;
    logic [15:0] chars_written;
    logic        enc_stopped;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned bytes_offered;
    int unsigned bytes_taken;
    int unsigned error_count;
    logic        took_byte;

    url_percent_encoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic url_safe(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            || (c >= CHAR_ZERO && c <= CHAR_NINE)
            || (c == CHAR_MINUS) || (c == CHAR_DOT) || (c == CHAR_TILDE);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        logic [7:0] letter_base;
        letter_base = upper_reg ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (n >= NIBBLE_TEN)
            return letter_base + {4'h0, n - NIBBLE_TEN};
        return CHAR_ZERO + {4'h0, n};
    endfunction

    function automatic void queue_result(input logic [7:0] b, input logic last,
                                         input logic drop);
        enc_char_t ch;
        ch = '{b, last, drop};
        expected_chars = {expected_chars, ch};
    endfunction

    function automatic void encode_byte(input logic [7:0] c);
        logic [16:0] room;
        logic [16:0] used;
        room = (buf_len_reg != 16'd0) ? {1'b0, buf_len_reg} - 17'd1 : 17'd0;
        used = {1'b0, chars_written};
        if (c == CHAR_NUL)
        begin
            queue_result(CHAR_NUL, 1'b1, 1'b0);
            chars_written = '0;
            enc_stopped   = 1'b0;
        end
        else if (enc_stopped || used >= room)
        begin
            enc_stopped = 1'b1;
            queue_result(CHAR_NUL, 1'b1, 1'b1);
        end
        else if (url_safe(c) || c == CHAR_SPACE)
        begin
            queue_result((c == CHAR_SPACE) ? CHAR_PLUS : c, 1'b1, 1'b0);
            chars_written = chars_written + 16'd1;
        end
        else if (used + 17'd3 > room)
        begin
            // escape does not fit, rest of the string is dropped
            enc_stopped = 1'b1;
            queue_result(CHAR_NUL, 1'b1, 1'b1);
        end
        else
        begin
            queue_result(CHAR_PERCENT, 1'b0, 1'b0);
            queue_result(nibble_char(c[7:4]), 1'b0, 1'b0);
            queue_result(nibble_char(c[3:0]), 1'b1, 1'b0);
            chars_written = chars_written + 16'd3;
        end
    endfunction

    // driver
    always @(negedge clk)
    begin : drive_inputs
        if (!s_axis_tvalid || took_byte)
        begin
            if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata  <= source_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                bytes_offered++;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : watch_outputs
        enc_char_t want;
        took_byte = rst_n && s_axis_tvalid && s_axis_tready;
        if (took_byte)
        begin
            bytes_taken++;
            encode_byte(s_axis_tdata);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got out_byte %h tlast %b tuser %b",
                         $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_axis_tdata !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h",
                             $time, want.out_byte, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tlast !== want.last_of_run)
                begin
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last_of_run, m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== want.dropped)
                begin
                    $display("%0t: dropped expected %b got %b",
                             $time, want.dropped, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_BUFFER_LENGTH)
            buf_len_reg = val;
        else
            upper_reg = val[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained;
        do
            @(negedge clk);
        while (source_bytes.size() != 0 || bytes_offered != bytes_taken
               || expected_chars.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = 76;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 76;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 33;
                recv_stall_pct = 33;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    function automatic logic [7:0] random_char();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            case ($urandom_range(3))
                0:       return CHAR_UPPER_A + 8'($urandom_range(25));
                1:       return CHAR_LOWER_A + 8'($urandom_range(25));
                2:       return CHAR_ZERO + 8'($urandom_range(9));
                default:
                    case ($urandom_range(2))
                        0:       return CHAR_MINUS;
                        1:       return CHAR_DOT;
                        default: return CHAR_TILDE;
                    endcase
            endcase
        end
        if (pick == 5)
            return CHAR_SPACE;
        return 8'($urandom_range(255, 1));
    endfunction

    // strings with random content, now and then run together without a terminator
    task automatic add_strings(input int unsigned n_bytes, input int unsigned max_str);
        int unsigned start;
        int unsigned len;
        start = source_bytes.size();
        while (source_bytes.size() - start < n_bytes)
        begin
            len = $urandom_range(max_str, 1);
            repeat (len) source_bytes = {source_bytes, random_char()};
            if ($urandom_range(9) != 0)
                source_bytes = {source_bytes, CHAR_NUL};
        end
    endtask

    task automatic run_phase(input idle_mode_t mode, input int unsigned n_bytes,
                             input int unsigned max_str);
        set_idling(mode);
        add_strings(n_bytes / 2, max_str);
        wait_drained();
        add_strings(n_bytes - n_bytes / 2, max_str);
        source_bytes = {source_bytes, CHAR_NUL};
        wait_drained();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        took_byte     = 1'b0;
        bytes_offered = 0;
        bytes_taken   = 0;
        error_count   = 0;
        buf_len_reg   = BUFFER_LENGTH_RESET[15:0];
        upper_reg     = UPPER_CASE_RESET;
        chars_written = '0;
        enc_stopped   = 1'b0;
        set_idling(IDLE_NONE);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: character classes and their borders
        source_bytes = '{8'h41, 8'h7A, 8'h30, 8'h39, 8'h2D, 8'h2E, 8'h7E, 8'h20,
                         8'h2F, 8'h40, 8'h7B, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'h00};
        wait_drained();

        // escape, then a plain byte filling the buffer exactly, buffer full, escape not fitting
        write_reg(REG_BUFFER_LENGTH, 16'd5);
        write_reg(REG_UPPER_CASE, 16'd0);
        source_bytes = '{8'hAB, 8'h78, 8'h79, 8'h00, 8'h20, 8'h71, 8'hC3, 8'h2D, 8'h00};
        wait_drained();

        // no room at all
        write_reg(REG_BUFFER_LENGTH, 16'd0);
        source_bytes = '{8'h61, 8'h00};
        wait_drained();

        write_reg(REG_BUFFER_LENGTH, 16'hFFFF);
        write_reg(REG_UPPER_CASE, 16'd1);
        run_phase(IDLE_NONE, 20, 12);

        write_reg(REG_BUFFER_LENGTH, 16'd1);
        write_reg(REG_UPPER_CASE, 16'd0);
        run_phase(IDLE_SEND, 12, 4);

        write_reg(REG_BUFFER_LENGTH, 16'($urandom_range(40, 8)));
        run_phase(IDLE_RECV, 24, 20);

        write_reg(REG_BUFFER_LENGTH, 16'($urandom_range(12, 2)));
        write_reg(REG_UPPER_CASE, 16'd1);
        run_phase(IDLE_BOTH, 24, 10);

        write_reg(REG_BUFFER_LENGTH, 16'd256);
        write_reg(REG_UPPER_CASE, 16'd0);
        run_phase(IDLE_BOTH, 20, 16);

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
hdl/uenc_pkg.sv
hdl/uenc_step.sv
hdl/uenc_serial.sv
hdl/url_percent_encoder.sv
tb/sv/tb_url_percent_encoder.sv
